/* hw/rtl/rte_pkg.sv */
package rte_pkg;

  // fixed field and register widths
  localparam int CharW      = 8;
  localparam int CfgDataW   = 16;
  localparam int CfgIndexW  = 2;
  localparam int SpreadW    = 12;

  // default structural parameters
  localparam int PhaseBitsDef   = 16;
  localparam int SineEntriesDef = 1024;

  // register reset values
  localparam logic [CfgDataW-1:0] PhaseStepRst  = 16'd104;
  localparam logic [SpreadW-1:0]  SpreadGainRst = 12'd256;
  localparam logic [CfgDataW-1:0] StartPhaseRst = 16'd0;

  // characters of the escape sequence
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChEsc     = 8'd27;
  localparam logic [CharW-1:0] ChBracket = 8'h5b;
  localparam logic [CharW-1:0] ChSemi    = 8'h3b;
  localparam logic [CharW-1:0] ChM       = 8'h6d;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChTwo     = 8'h32;
  localparam logic [CharW-1:0] ChThree   = 8'h33;
  localparam logic [CharW-1:0] ChEight   = 8'h38;

  // register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_SPREAD_GAIN = 2'd1,
    CFG_START_PHASE = 2'd2
  } cfg_idx_e;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // quarter-wave sine, Q30 in and out, odd Taylor terms up to x^11
  function automatic longint unsigned quarter_sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    return longint'(sum);
  endfunction

endpackage

/* hw/rtl/rainbow_truecolor_encoder.sv */
// Rainbow truecolor encoder: each request is one text byte. A newline passes
// through as one byte with last set and leaves the phase alone; any other byte
// comes out as ESC[38;2;R;G;Bm<byte>ESC[0m (18 to 24 bytes, last on the final
// one) with R, G and B taken from a sine table at the running phase plus one
// and two thirds of a turn, after which the phase advances by phase_step.
// Configuration writes (index 0 phase_step, 1 spread_gain, 2 start_phase,
// others ignored) are always ready and must only be issued while idle.
// A coloured byte holds the back end for colour work (ADDR, MUL and CLAMP for
// each channel) through the single table port and multiplier, then for the
// serializer, one template slot per cycle unless the output stalls. A newline
// is loaded at pop. A two-entry queue lets new bytes be taken while output drains.
module rainbow_truecolor_encoder #(
  parameter int PhaseBits   = rte_pkg::PhaseBitsDef,
  parameter int SineEntries = rte_pkg::SineEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rte_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [rte_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rte_pkg::CharW-1:0]     char_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rte_pkg::CharW-1:0]     out_byte_o,
  output logic                          last_o
);

  localparam int EntryW = PhaseBits + rte_pkg::CharW + 1;

  logic [rte_pkg::CfgDataW-1:0] phase_step_q;
  logic [rte_pkg::SpreadW-1:0]  spread_gain_q;
  logic [rte_pkg::CfgDataW-1:0] start_phase_q;

  logic                         push, pop;
  logic [EntryW-1:0]            push_data, pop_data;
  rte_pkg::fifo_stat_t          stat;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= rte_pkg::PhaseStepRst;
      spread_gain_q <= rte_pkg::SpreadGainRst;
      start_phase_q <= rte_pkg::StartPhaseRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rte_pkg::CFG_PHASE_STEP) begin
        phase_step_q <= cfg_data_i;
      end else if (cfg_index_i == rte_pkg::CFG_SPREAD_GAIN) begin
        spread_gain_q <= cfg_data_i[rte_pkg::SpreadW-1:0];
      end else if (cfg_index_i == rte_pkg::CFG_START_PHASE) begin
        start_phase_q <= cfg_data_i;
      end
    end
  end

  rte_front #(
    .PhaseBits (PhaseBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_byte_i   (char_byte_i),
    .phase_step_i  (phase_step_q),
    .start_phase_i (start_phase_q),
    .stat_i        (stat),
    .push_o        (push),
    .entry_o       (push_data)
  );

  rte_fifo #(
    .Width (EntryW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .stat_o (stat)
  );

  rte_back #(
    .PhaseBits   (PhaseBits),
    .SineEntries (SineEntries)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (pop_data),
    .stat_i        (stat),
    .pop_o         (pop),
    .spread_gain_i (spread_gain_q),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

endmodule

/* hw/rtl/rte_fifo.sv */
module rte_fifo #(
  parameter int Width = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [Width-1:0]    data_i,
  input  logic                pop_i,
  output logic [Width-1:0]    data_o,
  output rte_pkg::fifo_stat_t stat_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);

  // no overflow or underflow
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !stat_o.full || pop_i)
    else $error("request pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !stat_o.empty)
    else $error("request popped from empty queue");

endmodule

/* hw/rtl/rte_front.sv */
module rte_front #(
  parameter int PhaseBits = rte_pkg::PhaseBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rte_pkg::CharW-1:0]    char_byte_i,
  input  logic [rte_pkg::CfgDataW-1:0] phase_step_i,
  input  logic [rte_pkg::CfgDataW-1:0] start_phase_i,
  input  rte_pkg::fifo_stat_t          stat_i,
  output logic                         push_o,
  output logic [PhaseBits+rte_pkg::CharW:0] entry_o
);

  localparam int ExtW = PhaseBits + rte_pkg::CfgDataW;

  logic [PhaseBits-1:0] accum_q, accum_d;
  logic [ExtW-1:0]      step_ext, start_ext;
  logic [PhaseBits-1:0] step, start, theta;
  logic                 is_nl;

  // fit the 16-bit registers to the phase width
  assign step_ext  = {{PhaseBits{1'b0}}, phase_step_i};
  assign start_ext = {{PhaseBits{1'b0}}, start_phase_i};
  assign step      = step_ext[PhaseBits-1:0];
  assign start     = start_ext[PhaseBits-1:0];

  // classify and stamp each request with its phase
  assign in_ready_o = !stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;
  assign is_nl      = (char_byte_i == rte_pkg::ChNewline);
  assign theta      = start + accum_q;
  assign entry_o    = {is_nl, char_byte_i, theta};

  // coloured bytes advance the accumulator
  always_comb begin
    accum_d = accum_q;
    if (push_o && !is_nl) begin
      accum_d = accum_q + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
    end else begin
      accum_q <= accum_d;
    end
  end

endmodule

/* hw/rtl/rte_back.sv */
module rte_back #(
  parameter int PhaseBits   = rte_pkg::PhaseBitsDef,
  parameter int SineEntries = rte_pkg::SineEntriesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [PhaseBits+rte_pkg::CharW:0]   entry_i,
  input  rte_pkg::fifo_stat_t                 stat_i,
  output logic                                pop_o,
  input  logic [rte_pkg::SpreadW-1:0]         spread_gain_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [rte_pkg::CharW-1:0]           out_byte_o,
  output logic                                last_o
);

  localparam int IdxW = $clog2(SineEntries);
  localparam int EntW = $clog2(SineEntries + 1);
  localparam int PrdW = PhaseBits + EntW;
  localparam logic [PhaseBits-1:0] ThirdTurn =
    PhaseBits'(((64'd1 << PhaseBits) + 64'd1) / 64'd3);
  localparam logic [PhaseBits-1:0] TwoThirdTurn =
    PhaseBits'(((64'd2 << PhaseBits) + 64'd1) / 64'd3);
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // slots of the output template
  localparam logic [4:0] PosRed   = 5'd7;
  localparam logic [4:0] PosGreen = 5'd11;
  localparam logic [4:0] PosBlue  = 5'd15;
  localparam logic [4:0] PosLast  = 5'd23;

  typedef logic signed [15:0] sine_rom_t [SineEntries];

  // full-wave table mirrored from the quarter-wave series
  function automatic sine_rom_t build_sine();
    sine_rom_t       rom;
    longint unsigned four_n;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned part;
    longint unsigned x;
    longint unsigned s;
    longint unsigned q15;
    for (int n = 0; n < SineEntries; n++) begin
      four_n = 64'd4 * longint'(n);
      quad   = four_n / SineEntries;
      rem    = four_n - quad * SineEntries;
      part   = quad[0] ? (SineEntries - rem) : rem;
      x      = (part * HalfPiQ30) / SineEntries;
      s      = rte_pkg::quarter_sine_q30(x);
      q15    = (s * 64'd32767 + 64'd536870912) >> 30;
      if (q15 > 64'd32767) begin
        q15 = 64'd32767;
      end
      rom[n] = (quad >= 64'd2) ? -$signed(q15[15:0]) : $signed(q15[15:0]);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine();

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_MUL,
    S_CLAMP,
    S_EMIT
  } state_e;

  state_e                    state_q;
  logic [1:0]                k_q;
  logic [4:0]                pos_q;
  logic                      out_valid_q;
  logic [rte_pkg::CharW-1:0] out_byte_q;
  logic                      last_q;

  logic [PhaseBits-1:0]      theta_q;
  logic [rte_pkg::CharW-1:0] char_q;
  logic signed [15:0]        rom_q;
  logic signed [35:0]        prod_q;
  logic [7:0]                chan_q [3];

  logic                      out_free;
  logic                      entry_nl;
  logic [PhaseBits-1:0]      theta_k;
  logic [PrdW-1:0]           idx_prod;
  logic [EntW-1:0]           idx_full, idx_sat;
  logic [IdxW-1:0]           rom_idx;
  logic [18:0]               gain127;
  logic signed [35:0]        prod_d;
  logic signed [36:0]        level;
  logic [7:0]                chan_d;
  logic [7:0]                dval;
  logic [1:0]                hund;
  logic [7:0]                rest;
  logic [14:0]               tens_prod;
  logic [3:0]                tens;
  logic [7:0]                ones;
  logic [rte_pkg::CharW-1:0] slot_byte;
  logic                      slot_used;
  logic                      out_load;
  logic [rte_pkg::CharW-1:0] load_byte;
  logic                      load_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign entry_nl = entry_i[PhaseBits+rte_pkg::CharW];
  assign pop_o    = (state_q == S_IDLE) && !stat_i.empty && out_free;

  // table index for the current channel
  always_comb begin
    case (k_q)
      2'd0:    theta_k = theta_q;
      2'd1:    theta_k = theta_q + ThirdTurn;
      default: theta_k = theta_q + TwoThirdTurn;
    endcase
    idx_prod = PrdW'(theta_k) * PrdW'(SineEntries);
    idx_full = idx_prod[PrdW-1:PhaseBits];
    idx_sat  = (idx_full > EntW'(SineEntries - 1)) ? EntW'(SineEntries - 1) : idx_full;
    rom_idx  = idx_sat[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SineRom[rom_idx];
  end

  // amplitude scaling and clamp to a byte
  assign gain127 = {spread_gain_i, 7'd0} - {7'd0, spread_gain_i};
  assign prod_d  = 36'(rom_q) * 36'($signed({1'b0, gain127}));
  assign level   = {prod_q[35], prod_q} + 37'sh0_4000_0000;

  always_comb begin
    if (level[36]) begin
      chan_d = 8'd0;
    end else if (level[36:23] > 14'd255) begin
      chan_d = 8'd255;
    end else begin
      chan_d = level[30:23];
    end
  end

  // decimal digits of the channel under the serializer
  always_comb begin
    if (pos_q >= PosBlue) begin
      dval = chan_q[2];
    end else if (pos_q >= PosGreen) begin
      dval = chan_q[1];
    end else begin
      dval = chan_q[0];
    end
    hund      = (dval >= 8'd200) ? 2'd2 : ((dval >= 8'd100) ? 2'd1 : 2'd0);
    rest      = dval - ({6'd0, hund} * 8'd100);
    tens_prod = {7'd0, rest} * 15'd205;
    tens      = tens_prod[14:11];
    ones      = rest - ({4'd0, tens} * 8'd10);
  end

  // template byte at the current slot
  always_comb begin
    slot_used = 1'b1;
    case (pos_q)
      5'd0, 5'd20:                     slot_byte = rte_pkg::ChEsc;
      5'd1, 5'd21:                     slot_byte = rte_pkg::ChBracket;
      5'd2:                            slot_byte = rte_pkg::ChThree;
      5'd3:                            slot_byte = rte_pkg::ChEight;
      5'd4, 5'd6, 5'd10, 5'd14:        slot_byte = rte_pkg::ChSemi;
      5'd5:                            slot_byte = rte_pkg::ChTwo;
      PosRed, PosGreen, PosBlue: begin
        slot_byte = rte_pkg::ChZero + 8'(hund);
        slot_used = (dval >= 8'd100);
      end
      PosRed + 5'd1, PosGreen + 5'd1, PosBlue + 5'd1: begin
        slot_byte = rte_pkg::ChZero + 8'(tens);
        slot_used = (dval >= 8'd10);
      end
      PosRed + 5'd2, PosGreen + 5'd2, PosBlue + 5'd2: begin
        slot_byte = rte_pkg::ChZero + ones;
      end
      5'd18, PosLast:                  slot_byte = rte_pkg::ChM;
      5'd19:                           slot_byte = char_q;
      5'd22:                           slot_byte = rte_pkg::ChZero;
      default: begin
        slot_byte = rte_pkg::ChZero;
        slot_used = 1'b0;
      end
    endcase
  end

  // output register load: a newline at pop or a used template slot
  assign out_load  = (pop_o && entry_nl) ||
                     ((state_q == S_EMIT) && slot_used && out_free);
  assign load_byte = (state_q == S_IDLE) ? rte_pkg::ChNewline : slot_byte;
  assign load_last = (state_q == S_IDLE) || (pos_q == PosLast);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= 2'd0;
      pos_q       <= 5'd0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= load_byte;
        last_q      <= load_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o && !entry_nl) begin
            k_q     <= 2'd0;
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          if (k_q == 2'd2) begin
            pos_q   <= 5'd0;
            state_q <= S_EMIT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_ADDR;
          end
        end
        S_EMIT: begin
          if (!slot_used || out_free) begin
            if (pos_q == PosLast) begin
              state_q <= S_IDLE;
            end else begin
              pos_q <= pos_q + 5'd1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      theta_q <= entry_i[PhaseBits-1:0];
      char_q  <= entry_i[PhaseBits+rte_pkg::CharW-1:PhaseBits];
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_CLAMP) begin
      chan_q[k_q] <= chan_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) k_q <= 2'd2)
    else $error("channel counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && out_byte_o != rte_pkg::ChNewline) |-> out_byte_o == rte_pkg::ChM)
    else $error("coloured request does not end in reset sequence");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && out_ready_i) |=> state_q != S_EMIT)
    else $error("serializer still running after final byte");

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseBits   = rte_pkg::PhaseBitsDef;
  localparam int SineEntries = rte_pkg::SineEntriesDef;
  localparam int ClkPeriod   = 8;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 40;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam logic [PhaseBits-1:0] ThirdTurn    = PhaseBits'(((1 << PhaseBits) + 1) / 3);
  localparam logic [PhaseBits-1:0] TwoThirdTurn = PhaseBits'(((2 << PhaseBits) + 1) / 3);
  // index that maps to no register
  localparam logic [rte_pkg::CfgIndexW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [rte_pkg::CharW-1:0] data;
    logic                      last;
  } stream_byte_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [rte_pkg::CfgIndexW-1:0] cfg_index_i;
  logic [rte_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [rte_pkg::CharW-1:0]     char_byte_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [rte_pkg::CharW-1:0]     out_byte_o;
  logic                          last_o;

  // expected output stream and predictor state
  stream_byte_t                  exp_stream[$];
  longint                        sine_q15[SineEntries];
  logic [rte_pkg::CfgDataW-1:0]  mdl_step;
  logic [rte_pkg::SpreadW-1:0]   mdl_spread;
  logic [rte_pkg::CfgDataW-1:0]  mdl_start;
  logic [PhaseBits-1:0]          mdl_phase;

  int err_cnt       = 0;
  int stall_cnt     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  rainbow_truecolor_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // sin over a quarter wave, Q30 in and out
  function automatic longint quarter_wave(input longint unsigned x);
    longint unsigned x_sq;
    longint unsigned term;
    longint unsigned div;
    longint          acc;
    x_sq = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      div  = longint'((2 * k) * (2 * k + 1));
      term = ((term * x_sq) >> 30) / div;
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return acc;
  endfunction

  // full-wave Q1.15 table, mirrored from the quarter wave
  task automatic build_sine_table();
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned part;
    longint          q;
    for (int n = 0; n < SineEntries; n++) begin
      quad = (4 * n) / SineEntries;
      rem  = (4 * n) - quad * SineEntries;
      part = quad[0] ? (SineEntries - rem) : rem;
      q    = (quarter_wave((part * HalfPiQ30) / SineEntries) * 32767 +
              (longint'(1) << 29)) / (longint'(1) << 30);
      if (q > 32767) begin
        q = 32767;
      end
      sine_q15[n] = (quad >= 2) ? -q : q;
    end
  endtask

  // one colour channel at a given phase
  function automatic logic [7:0] color_level(input logic [PhaseBits-1:0] theta);
    longint unsigned idx;
    longint          v;
    idx = (longint'(theta) * SineEntries) >> PhaseBits;
    v   = sine_q15[idx] * 127 * longint'(mdl_spread) + (longint'(128) << 23);
    if (v < 0) begin
      return 8'd0;
    end
    v = v >>> 23;
    if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  task automatic push_plain(input logic [rte_pkg::CharW-1:0] b);
    exp_stream.push_back('{data: b, last: 1'b0});
  endtask

  task automatic push_decimal(input logic [7:0] v);
    if (v >= 8'd100) begin
      push_plain(rte_pkg::ChZero + v / 8'd100);
    end
    if (v >= 8'd10) begin
      push_plain(rte_pkg::ChZero + (v / 8'd10) % 8'd10);
    end
    push_plain(rte_pkg::ChZero + v % 8'd10);
  endtask

  // expected escape-wrapped bytes for one text byte
  task automatic encode_char(input logic [rte_pkg::CharW-1:0] c);
    logic [PhaseBits-1:0] theta;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    if (c == rte_pkg::ChNewline) begin
      exp_stream.push_back('{data: c, last: 1'b1});
      return;
    end
    theta = mdl_start + mdl_phase;
    red   = color_level(theta);
    green = color_level(theta + ThirdTurn);
    blue  = color_level(theta + TwoThirdTurn);
    push_plain(rte_pkg::ChEsc);
    push_plain(rte_pkg::ChBracket);
    push_plain(rte_pkg::ChThree);
    push_plain(rte_pkg::ChEight);
    push_plain(rte_pkg::ChSemi);
    push_plain(rte_pkg::ChTwo);
    push_plain(rte_pkg::ChSemi);
    push_decimal(red);
    push_plain(rte_pkg::ChSemi);
    push_decimal(green);
    push_plain(rte_pkg::ChSemi);
    push_decimal(blue);
    push_plain(rte_pkg::ChM);
    push_plain(c);
    push_plain(rte_pkg::ChEsc);
    push_plain(rte_pkg::ChBracket);
    push_plain(rte_pkg::ChZero);
    push_plain(rte_pkg::ChM);
    exp_stream[exp_stream.size() - 1].last = 1'b1;
    mdl_phase = mdl_phase + mdl_step;
  endtask

  // send one request; entered and left at a falling edge
  task automatic send_char(input logic [rte_pkg::CharW-1:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    encode_char(c);
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // let the output drain, then give the back end time to settle
  task automatic wait_drained();
    while (exp_stream.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [rte_pkg::CfgIndexW-1:0] idx,
                           input logic [rte_pkg::CfgDataW-1:0]  data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rte_pkg::CFG_PHASE_STEP:  mdl_step = data;
      rte_pkg::CFG_SPREAD_GAIN: mdl_spread = data[rte_pkg::SpreadW-1:0];
      rte_pkg::CFG_START_PHASE: mdl_start = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [rte_pkg::CfgDataW-1:0] step,
                              input logic [rte_pkg::CfgDataW-1:0] spread,
                              input logic [rte_pkg::CfgDataW-1:0] start);
    write_reg(rte_pkg::CFG_PHASE_STEP, step);
    write_reg(rte_pkg::CFG_SPREAD_GAIN, spread);
    write_reg(rte_pkg::CFG_START_PHASE, start);
  endtask

  // printable text with newlines and some arbitrary bytes
  function automatic logic [rte_pkg::CharW-1:0] random_char();
    if ($urandom_range(9) == 0) begin
      return rte_pkg::ChNewline;
    end
    if ($urandom_range(4) == 0) begin
      return rte_pkg::CharW'($urandom_range(255));
    end
    return rte_pkg::CharW'($urandom_range(126, 32));
  endfunction

  task automatic test_reset_values();
    send_char(8'h41);
    send_char(rte_pkg::ChNewline);
    send_char(8'h00);
    send_char(8'hff);
    send_char(8'h55);
    send_char(8'haa);
    stop_sending();
    wait_drained();
  endtask

  // no phase advance and flat colour
  task automatic test_zero_step_zero_spread();
    program_regs(16'd0, 16'd0, 16'd0);
    send_char(8'h61);
    send_char(8'h62);
    send_char(8'h7e);
    stop_sending();
    wait_drained();
  endtask

  // saturating channels with the widest phase values
  task automatic test_large_spread();
    program_regs(16'hffff, 16'h0fff, 16'hffff);
    send_char(8'h78);
    send_char(rte_pkg::ChNewline);
    send_char(8'h79);
    send_char(8'h7a);
    stop_sending();
    wait_drained();
  endtask

  // wide spread value is masked, spare index changes nothing
  task automatic test_masked_and_unknown();
    write_reg(rte_pkg::CFG_SPREAD_GAIN, 16'hf0c0);
    write_reg(CfgIdxSpare, 16'hffff);
    write_reg(rte_pkg::CFG_START_PHASE, ThirdTurn);
    write_reg(rte_pkg::CFG_PHASE_STEP, 16'd1);
    send_char(8'h71);
    send_char(8'h72);
    send_char(8'h73);
    send_char(rte_pkg::ChNewline);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int blk = 0; blk < 2; blk++) begin
      case ($urandom_range(3))
        0: program_regs(16'd1, 16'd1, 16'd0);
        1: program_regs(16'hffff, 16'h0fff, 16'hffff);
        default: program_regs(rte_pkg::CfgDataW'($urandom_range(65535)),
                              rte_pkg::CfgDataW'($urandom_range(4095)),
                              rte_pkg::CfgDataW'($urandom_range(65535)));
      endcase
      for (int i = 0; i < n_items / 2; i++) begin
        send_char(random_char());
      end
      // sender holds off until everything has come out
      stop_sending();
      wait_drained();
    end
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each output byte with the oldest expectation
  always @(posedge clk_i) begin
    stream_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_stream.size() == 0) begin
        $display("%0t: unexpected output byte %h last %b", $time, out_byte_o, last_o);
        err_cnt++;
      end else begin
        want = exp_stream.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte_o);
          err_cnt++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    char_byte_i = '0;
    build_sine_table();
    mdl_step   = rte_pkg::PhaseStepRst;
    mdl_spread = rte_pkg::SpreadGainRst;
    mdl_start  = rte_pkg::StartPhaseRst;
    mdl_phase  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 59;
    test_reset_values();
    test_zero_step_zero_spread();
    test_large_spread();
    test_masked_and_unknown();
    test_random_traffic(20, 59, 68);
    test_random_traffic(59, 20, 68);
    test_random_traffic(0, 0, 68);

    wait_drained();
    if (exp_stream.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, exp_stream.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
